// File: rtl/prf_pkg.sv
// ----------------------------------------------------------------------------
// prf_pkg
// Shared types and constants for the capture record framer.
// ----------------------------------------------------------------------------
package prf_pkg;

    localparam int unsigned C_S_TDATA_W      = 200;
    localparam int unsigned C_M_TDATA_W      = 8;
    localparam int unsigned C_QUEUE_DEPTH    = 2;

    localparam logic [3:0]  C_MAX_DATA_BYTES = 4'd15;
    localparam int unsigned C_USEC_PER_SEC   = 1000000;
    localparam logic [7:0]  C_SYNC_BYTE      = 8'hAA;
    // length field: two meta bytes plus four fixed frame bytes plus data
    localparam logic [7:0]  C_FIXED_LEN      = 8'd6;

    // byte positions within a record
    localparam logic [5:0]  C_POS_CHAN       = 6'd16;
    localparam logic [5:0]  C_POS_FLAG       = 6'd17;
    localparam logic [5:0]  C_POS_SYNC       = 6'd18;
    localparam logic [5:0]  C_POS_ADDR       = 6'd19;
    localparam logic [5:0]  C_POS_OPC        = 6'd20;
    localparam logic [5:0]  C_POS_DATA       = 6'd21;

    typedef struct packed {
        logic [7:0]   channel_id;
        logic [7:0]   flag_bits;
        logic [7:0]   node_address;
        logic [7:0]   opcode_byte;
        logic [3:0]   payload_count;
        logic [119:0] payload;
        logic [7:0]   check_byte;
    } t_meta;

    typedef struct packed {
        logic [63:0] total_us;
        t_meta       meta;
    } t_pkt;

    typedef struct packed {
        logic [31:0] seconds;
        logic [19:0] micros;
        t_meta       meta;
    } t_rec;

endpackage

// File: rtl/pcap_record_framer.sv
// ----------------------------------------------------------------------------
// pcap_record_framer
// Turns one captured bus packet into one PCAP packet record, byte by byte.
// ----------------------------------------------------------------------------
// Slave stream: one transaction per packet. tdata carries timestamp, channel,
// flags, address, command, data byte count, data bytes and checksum; tuser
// is the room flag. A packet with tuser low is taken and dropped: no bytes,
// and the timestamp wrap tracking is left as it was.
// Master stream: one record byte per transaction, tlast on the checksum byte.
// A record is 22 + n bytes, n the data byte count (saturated to 15).
// The first record byte waits on the seconds/microseconds divider, which
// works four bits a cycle. The one-byte output sets the record rate; the
// divider works on the next packet while the current record is streamed,
// so with the sink always ready records follow back to back. A two-entry
// packet queue lets the slave
// side keep accepting while the master side is stalled; when the sink holds
// tready low the output byte is held and the queue fills, then the slave
// tready drops. Synchronous reset clears the wrap state and all queues.
// ----------------------------------------------------------------------------
module pcap_record_framer #(
    parameter int unsigned QUEUE_DEPTH = prf_pkg::C_QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // stamp_us, channel_id, flag_bits, node_address, opcode_byte,
    // payload_count, payload_low, payload_high, check_byte, zero pad
    input  logic [prf_pkg::C_S_TDATA_W-1:0]  i_s_tdata,
    // room_ok
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // out_byte
    output logic [prf_pkg::C_M_TDATA_W-1:0]  o_m_tdata,
    output logic                             o_m_tlast
);
    import prf_pkg::*;

    logic push, full, pop, empty, rec_valid, rec_ready;
    t_pkt front_pkt, queue_pkt;
    t_rec rec;

    prf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_full     (full),
        .o_push     (push),
        .o_pkt      (front_pkt)
    );

    prf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pkt   (front_pkt),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_pkt   (queue_pkt)
    );

    prf_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_pkt       (queue_pkt),
        .o_pop       (pop),
        .o_rec_valid (rec_valid),
        .i_rec_ready (rec_ready),
        .o_rec       (rec)
    );

    prf_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (rec_valid),
        .o_rec_ready (rec_ready),
        .i_rec       (rec),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

// File: rtl/prf_front.sv
// ----------------------------------------------------------------------------
// prf_front
// Accepts packets, drops those without room, extends the timestamp.
// ----------------------------------------------------------------------------
module prf_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [prf_pkg::C_S_TDATA_W-1:0]  i_s_tdata,
    input  logic                             i_s_tuser,
    input  logic                             i_full,
    output logic                             o_push,
    output prf_pkg::t_pkt                    o_pkt
);
    import prf_pkg::*;

    logic [31:0] r_prev_stamp, n_prev_stamp;
    logic [31:0] r_wrap_total, n_wrap_total;
    logic [31:0] stamp;
    logic [3:0]  count_in;
    logic        accept;

    assign stamp      = i_s_tdata[31:0];
    assign count_in   = i_s_tdata[67:64];
    assign o_s_tready = !i_full;
    assign accept     = i_s_tvalid && !i_full;
    assign o_push     = accept && i_s_tuser;

    always_comb begin
        n_prev_stamp = r_prev_stamp;
        n_wrap_total = r_wrap_total;
        if (o_push) begin
            n_prev_stamp = stamp;
            if (stamp < r_prev_stamp) begin
                n_wrap_total = r_wrap_total + 32'd1;
            end
        end
    end

    always_comb begin
        o_pkt.total_us           = {n_wrap_total, stamp};
        o_pkt.meta.channel_id    = i_s_tdata[39:32];
        o_pkt.meta.flag_bits     = i_s_tdata[47:40];
        o_pkt.meta.node_address  = i_s_tdata[55:48];
        o_pkt.meta.opcode_byte   = i_s_tdata[63:56];
        o_pkt.meta.payload_count = (count_in > C_MAX_DATA_BYTES) ? C_MAX_DATA_BYTES : count_in;
        o_pkt.meta.payload       = i_s_tdata[187:68];
        o_pkt.meta.check_byte    = i_s_tdata[195:188];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_stamp <= '0;
            r_wrap_total <= '0;
        end else begin
            r_prev_stamp <= n_prev_stamp;
            r_wrap_total <= n_wrap_total;
        end
    end

endmodule

// File: rtl/prf_queue.sv
// ----------------------------------------------------------------------------
// prf_queue
// Short packet queue between the front end and the divider.
// ----------------------------------------------------------------------------
module prf_queue #(
    parameter int unsigned DEPTH = prf_pkg::C_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  prf_pkg::t_pkt i_pkt,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output prf_pkg::t_pkt o_pkt
);
    import prf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_pkt             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_pkt   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/prf_divider.sv
// ----------------------------------------------------------------------------
// prf_divider
// Splits the 64-bit microsecond count into seconds and microseconds,
// four quotient bits per cycle.
// ----------------------------------------------------------------------------
module prf_divider (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  prf_pkg::t_pkt i_pkt,
    output logic          o_pop,
    output logic          o_rec_valid,
    input  logic          i_rec_ready,
    output prf_pkg::t_rec o_rec
);
    import prf_pkg::*;

    localparam logic [20:0] C_DIVISOR = 21'(C_USEC_PER_SEC);

    logic        r_busy, r_res_valid;
    logic [3:0]  r_step;
    logic [63:0] r_work, n_work;
    logic [19:0] r_rem, n_rem;
    t_meta       r_meta;
    logic [20:0] trial;

    assign o_pop       = !r_busy && !r_res_valid && !i_empty;
    assign o_rec_valid = r_res_valid;

    always_comb begin
        n_work = r_work;
        n_rem  = r_rem;
        trial  = '0;
        for (int k = 0; k < 4; k++) begin
            trial  = {n_rem, n_work[63]};
            n_work = {n_work[62:0], 1'b0};
            if (trial >= C_DIVISOR) begin
                trial     = trial - C_DIVISOR;
                n_work[0] = 1'b1;
            end
            n_rem = trial[19:0];
        end
    end

    always_comb begin
        o_rec.seconds = r_work[31:0];
        o_rec.micros  = r_rem;
        o_rec.meta    = r_meta;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_pkt.total_us;
            r_rem  <= '0;
            r_meta <= i_pkt.meta;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_res_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == 4'hF) begin
                    r_busy      <= 1'b0;
                    r_res_valid <= 1'b1;
                end
            end else if (r_res_valid && i_rec_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/prf_serializer.sv
// ----------------------------------------------------------------------------
// prf_serializer
// Emits one record a byte per cycle while the sink is ready, through a registered output.
// ----------------------------------------------------------------------------
module prf_serializer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_rec_valid,
    output logic                             o_rec_ready,
    input  prf_pkg::t_rec                    i_rec,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [prf_pkg::C_M_TDATA_W-1:0]  o_m_tdata,
    output logic                             o_m_tlast
);
    import prf_pkg::*;

    t_rec         r_rec;
    logic         r_busy;
    logic [5:0]   r_idx;
    logic         r_out_valid, r_out_last;
    logic [7:0]   r_out_byte;
    logic         advance, emit, last_pos, load;
    logic [5:0]   last_idx;
    logic [3:0]   data_idx;
    logic [7:0]   plen;
    logic [127:0] hdr;
    logic [7:0]   cur_byte;

    assign advance     = !r_out_valid || i_m_tready;
    assign emit        = r_busy && advance;
    assign last_idx    = C_POS_DATA + 6'(r_rec.meta.payload_count);
    assign last_pos    = (r_idx == last_idx);
    assign o_rec_ready = !r_busy || (emit && last_pos);
    assign load        = i_rec_valid && o_rec_ready;
    assign data_idx    = 4'(r_idx - C_POS_DATA);
    assign plen        = C_FIXED_LEN + 8'(r_rec.meta.payload_count);
    assign hdr         = {24'd0, plen, 24'd0, plen, 12'd0, r_rec.micros, r_rec.seconds};

    always_comb begin
        if (r_idx < C_POS_CHAN) begin
            cur_byte = hdr[r_idx[3:0]*8 +: 8];
        end else if (r_idx == C_POS_CHAN) begin
            cur_byte = r_rec.meta.channel_id;
        end else if (r_idx == C_POS_FLAG) begin
            cur_byte = r_rec.meta.flag_bits;
        end else if (r_idx == C_POS_SYNC) begin
            cur_byte = C_SYNC_BYTE;
        end else if (r_idx == C_POS_ADDR) begin
            cur_byte = r_rec.meta.node_address;
        end else if (r_idx == C_POS_OPC) begin
            cur_byte = r_rec.meta.opcode_byte;
        end else if (last_pos) begin
            cur_byte = r_rec.meta.check_byte;
        end else begin
            cur_byte = r_rec.meta.payload[data_idx*8 +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= i_rec;
        end
        if (advance) begin
            r_out_byte <= cur_byte;
            r_out_last <= last_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= emit;
            end
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                r_idx <= r_idx + 1'b1;
                if (last_pos) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

endmodule

// File: rtl/prf_checker.sv
// ----------------------------------------------------------------------------
// prf_checker
// Port-level checks on the record stream of the framer.
// ----------------------------------------------------------------------------
module prf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [prf_pkg::C_S_TDATA_W-1:0]  i_s_tdata,
    input logic                             i_s_tuser,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [prf_pkg::C_M_TDATA_W-1:0]  o_m_tdata,
    input logic                             o_m_tlast
);
    import prf_pkg::*;

    logic [5:0] r_pos;
    logic       out_xfer;

    assign out_xfer = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (out_xfer) begin
            r_pos <= o_m_tlast ? '0 : r_pos + 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid straight after reset");

    a_sync_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_pos == C_POS_SYNC |-> o_m_tdata == C_SYNC_BYTE)
        else $error("sync byte misplaced");

    a_rec_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_m_tlast |-> r_pos >= C_POS_DATA && r_pos <= 6'd36)
        else $error("record length out of range");

    a_no_early_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_pos < C_POS_DATA |-> !o_m_tlast)
        else $error("end of record inside header");

endmodule

bind pcap_record_framer prf_checker u_prf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the capture record framer. Packets go in on the
// slave stream, record bytes are collected from the master stream and
// compared byte by byte, tlast included, with records predicted from the
// extended timestamp. Directed corner packets come first, then random
// packets under varying source and sink idling, with one long sink
// hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

    import prf_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES   = 100;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned RANDOM_ITEMS   = 240;

    class record_scoreboard;
        logic [31:0] last_stamp;
        logic [31:0] wrap_count;
        logic [8:0]  byte_queue[$];   // {tlast, byte}
        int          errors;

        function new();
            last_stamp = '0;
            wrap_count = '0;
            errors     = 0;
        endfunction

        function void push_le32(logic [31:0] v);
            for (int k = 0; k < 4; k++) begin
                byte_queue.push_back({1'b0, v[8*k +: 8]});
            end
        endfunction

        function void note_packet(logic [C_S_TDATA_W-1:0] d, logic room);
            logic [31:0]  stamp;
            logic [3:0]   cnt;
            logic [119:0] data;
            logic [63:0]  total;
            logic [31:0]  secs;
            logic [31:0]  usec;
            logic [31:0]  plen;
            stamp = d[31:0];
            cnt   = d[67:64];
            data  = d[187:68];
            if (!room) return;
            if (cnt > C_MAX_DATA_BYTES) cnt = C_MAX_DATA_BYTES;
            if (stamp < last_stamp) wrap_count = wrap_count + 32'd1;
            last_stamp = stamp;
            total = {wrap_count, stamp};
            secs  = 32'(total / 64'(C_USEC_PER_SEC));
            usec  = 32'(total % 64'(C_USEC_PER_SEC));
            plen  = 32'(C_FIXED_LEN) + 32'(cnt);
            push_le32(secs);
            push_le32(usec);
            push_le32(plen);
            push_le32(plen);
            byte_queue.push_back({1'b0, d[39:32]});
            byte_queue.push_back({1'b0, d[47:40]});
            byte_queue.push_back({1'b0, C_SYNC_BYTE});
            byte_queue.push_back({1'b0, d[55:48]});
            byte_queue.push_back({1'b0, d[63:56]});
            for (int i = 0; i < int'(cnt); i++) begin
                byte_queue.push_back({1'b0, data[8*i +: 8]});
            end
            byte_queue.push_back({1'b1, d[195:188]});
        endfunction

        task report_mismatch(string what, logic [8:0] got, logic [8:0] want);
            errors++;
            $display("mismatch: %s got %h want %h", what, got, want);
        endtask

        task check_byte(logic [7:0] b, logic last);
            logic [8:0] want;
            if (byte_queue.size() == 0) begin
                report_mismatch("unexpected byte", {last, b}, 9'h0);
                return;
            end
            want = byte_queue.pop_front();
            if (b !== want[7:0]) report_mismatch("tdata", {1'b0, b}, {1'b0, want[7:0]});
            if (last !== want[8]) report_mismatch("tlast", {8'h0, last}, {8'h0, want[8]});
        endtask

        function int pending();
            return byte_queue.size();
        endfunction
    endclass

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [C_S_TDATA_W-1:0] s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [C_M_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_go        = 1'b0;
    logic        hold_seen      = 1'b0;
    int unsigned hold_left      = 0;
    int unsigned idle_cycles    = 0;

    record_scoreboard sb = new();

    pcap_record_framer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // sink readiness, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_go && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_byte(m_tdata, m_tlast);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [C_S_TDATA_W-1:0] pack_packet(
        logic [31:0] stamp, logic [7:0] chan, logic [7:0] flags, logic [7:0] addr,
        logic [7:0] opc, logic [3:0] cnt, logic [63:0] lo, logic [55:0] hi,
        logic [7:0] chk);
        logic [C_S_TDATA_W-1:0] d;
        d = '0;
        d[31:0]    = stamp;
        d[39:32]   = chan;
        d[47:40]   = flags;
        d[55:48]   = addr;
        d[63:56]   = opc;
        d[67:64]   = cnt;
        d[131:68]  = lo;
        d[187:132] = hi;
        d[195:188] = chk;
        return d;
    endfunction

    task automatic send_packet(logic [C_S_TDATA_W-1:0] d, logic room);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= room;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_packet(d, room);
    endtask

    task automatic send_simple(logic [31:0] stamp, logic [3:0] cnt, logic room);
        send_packet(pack_packet(stamp, $urandom, $urandom, $urandom, $urandom, cnt,
                                {$urandom, $urandom}, {$urandom, $urandom}, $urandom),
                    room);
    endtask

    function automatic logic [31:0] next_stamp(logic [31:0] prev);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70) return prev + $urandom_range(1, 5000000);
        if (pick < 85) return $urandom;
        if (pick < 92) return 32'hFFFF_FFFF - $urandom_range(0, 3000000);
        return prev;
    endfunction

    task automatic send_random(ref logic [31:0] stamp);
        stamp = next_stamp(stamp);
        send_simple(stamp, 4'($urandom_range(15)), $urandom_range(99) >= 15);
    endtask

    initial begin
        logic [31:0] stamp;
        int          idx;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_packet(pack_packet(32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 4'd0,
                                64'h0, 56'h0, 8'h00), 1'b1);
        send_packet(pack_packet(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd15,
                                {64{1'b1}}, {56{1'b1}}, 8'hFF), 1'b1);
        send_simple(32'd5, 4'd8, 1'b1);           // wrap
        send_simple(32'd0, 4'd3, 1'b0);           // dropped, no wrap counted
        send_simple(32'd10, 4'd1, 1'b1);
        send_simple(32'd10, 4'd2, 1'b1);          // equal stamp, no wrap
        send_simple(32'd999_999, 4'd7, 1'b1);
        send_simple(32'd1_000_000, 4'd9, 1'b1);
        send_simple(32'd1_000_001, 4'd14, 1'b1);
        send_simple(32'hFFFF_FFFF, 4'd15, 1'b0);  // dropped
        send_simple(32'hFFFF_FFFE, 4'd4, 1'b1);
        send_simple(32'd1, 4'd15, 1'b1);          // wrap
        send_simple(32'd0, 4'd0, 1'b0);
        send_simple(32'd0, 4'd0, 1'b1);           // wrap
        send_packet(pack_packet(32'h5555_5555, 8'h55, 8'hAA, 8'h55, 8'hAA, 4'd15,
                                64'h5555_5555_5555_5555, 56'hAA_AAAA_AAAA_AAAA, 8'h5A),
                    1'b1);
        send_packet(pack_packet(32'hAAAA_AAAA, 8'hAA, 8'h55, 8'hAA, 8'h55, 4'd15,
                                64'hAAAA_AAAA_AAAA_AAAA, 56'h55_5555_5555_5555, 8'hA5),
                    1'b1);
        for (idx = 5; idx < 13; idx += 2) send_simple(32'hAAAA_AAAA + idx, 4'(idx), 1'b1);

        // long sink hold-off while the source keeps offering
        hold_go <= 1'b1;
        stamp = 32'hAAAA_AAB0;
        for (idx = 0; idx < 12; idx++) begin
            stamp = stamp + $urandom_range(1, 1000);
            send_simple(stamp, 4'($urandom_range(15)), 1'b1);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            for (idx = 0; idx < RANDOM_ITEMS / 4; idx++) send_random(stamp);
        end

        s_tvalid <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
